// ===== rtl/pfe_pkg.sv =====
// Shared types, codes and helper functions for the Playfair digraph encryptor.
// Used by every module under rtl/; depends on nothing else.

package pfe_pkg;

    // Action codes carried by an input item
    localparam logic [1:0] ACT_KEY   = 2'd0;
    localparam logic [1:0] ACT_MSG   = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Letter indexes (A = 0) and square geometry
    localparam logic [4:0] LETTER_I    = 5'd8;
    localparam logic [4:0] LETTER_J    = 5'd9;
    localparam logic [4:0] LETTER_X    = 5'd23;
    localparam logic [4:0] LETTER_LAST = 5'd25;
    localparam logic [4:0] SQUARE_SIZE = 5'd25;
    localparam logic [7:0] ASCII_A     = 8'd65;
    localparam logic [7:0] ASCII_Z     = 8'd90;
    localparam logic [2:0] ROW_LAST    = 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] letter;
    } in_item_t;

    typedef struct packed {
        logic [6:0] cipher_first;
        logic [6:0] cipher_second;
        logic       final_pair;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear;
        logic key_put;
        logic fill_step;
        logic eval;
        logic sq_read;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic complete;
        logic walk_last;
        logic emit;
        logic out_free;
        logic fill_full;
    } status_t;

    // Map an ASCII byte to a letter index with J folded to I; bit 5 flags a letter
    function automatic logic [5:0] to_index(input logic [7:0] ch);
        logic [7:0] d;
        logic [4:0] idx;
        logic       ok;
        d   = ch - ASCII_A;
        idx = d[4:0];
        ok  = (ch >= ASCII_A) && (ch <= ASCII_Z);
        if (idx == LETTER_J) begin
            idx = LETTER_I;
        end
        return {ok, idx};
    endfunction

    // Row of a cell 0..24
    function automatic logic [2:0] cell_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    // Row start cell: row * 5
    function automatic logic [4:0] row_base(input logic [2:0] r);
        return {r, 2'b00} + {2'b00, r};
    endfunction

    function automatic logic [2:0] cell_col(input logic [4:0] p);
        logic [4:0] c;
        c = p - row_base(cell_row(p));
        return c[2:0];
    endfunction

    function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
        return row_base(r) + {2'b00, c};
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == ROW_LAST) ? 3'd0 : v + 3'd1;
    endfunction

    // Output cells {oa, ob} for a pair at cells pa, pb
    function automatic logic [9:0] pair_cells(input logic [4:0] pa, input logic [4:0] pb);
        logic [2:0] ra, ca, rb, cb;
        logic [4:0] oa, ob;
        ra = cell_row(pa);
        ca = cell_col(pa);
        rb = cell_row(pb);
        cb = cell_col(pb);
        if (ca == cb) begin
            oa = cell_at(wrap_inc(ra), ca);
            ob = cell_at(wrap_inc(rb), cb);
        end else if (ra == rb) begin
            oa = cell_at(ra, wrap_inc(ca));
            ob = cell_at(rb, wrap_inc(cb));
        end else begin
            oa = cell_at(ra, cb);
            ob = cell_at(rb, ca);
        end
        return {oa, ob};
    endfunction

endpackage

// ===== rtl/pfe_ctrl.sv =====
// Sequencing state machine for the Playfair encryptor.
// Depends on pfe_pkg (cmd_t, status_t, action codes).

module pfe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [1:0]        s_action,
    output logic              s_ready,
    output pfe_pkg::cmd_t     cmd,
    input  pfe_pkg::status_t  status
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_KEY  = 6'b000010,
        ST_FILL = 6'b000100,
        ST_EVAL = 6'b001000,
        ST_SQ   = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (s_action == pfe_pkg::ACT_CLEAR) begin
                        cmd.clear = 1'b1;
                    end else if (s_action == pfe_pkg::ACT_KEY) begin
                        state_next = ST_KEY;
                    end else if (s_action inside {pfe_pkg::ACT_MSG, pfe_pkg::ACT_END}) begin
                        state_next = status.complete ? ST_EVAL : ST_FILL;
                    end
                end
            end
            ST_KEY: begin
                cmd.key_put = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (status.walk_last) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = status.emit ? ST_SQ : ST_IDLE;
            end
            ST_SQ: begin
                cmd.sq_read = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/pfe_datapath.sv =====
// Datapath of the Playfair encryptor: key square and position memories,
// used-letter flags, pending letter, pair lookup and output register.
// Depends on pfe_pkg.

module pfe_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  pfe_pkg::in_item_t   s_item,
    input  pfe_pkg::cmd_t       cmd,
    output pfe_pkg::status_t    status,
    output logic                m_valid,
    input  logic                m_ready,
    output pfe_pkg::out_item_t  m_item
);

    // Key square and letter-to-cell map
    logic [4:0] sq_mem  [0:24];
    logic [4:0] pos_mem [0:25];

    logic [1:0]  act_reg;
    logic [4:0]  idx_reg;
    logic        idx_ok_reg;
    logic [25:0] used_reg;
    logic [4:0]  fill_reg;
    logic        complete_reg;
    logic        pend_valid_reg;
    logic [4:0]  pend_letter_reg;
    logic [4:0]  walk_reg;
    logic [4:0]  pa_reg, pb_reg;
    logic        fin_reg;
    logic [4:0]  qa_reg, qb_reg;
    logic        m_valid_reg;
    pfe_pkg::out_item_t m_item_reg;

    logic [5:0] in_idx;
    logic       put_en;
    logic [4:0] put_letter;
    logic       do_put;
    logic       is_end;
    logic       is_msg;
    logic [4:0] second;
    logic [9:0] cells;

    assign in_idx = pfe_pkg::to_index(s_item.letter);
    assign is_end = (act_reg == pfe_pkg::ACT_END);
    assign is_msg = (act_reg == pfe_pkg::ACT_MSG);

    // Select the letter to place: the key letter, or the next letter of the walk
    always_comb begin
        put_en     = 1'b0;
        put_letter = walk_reg;
        if (cmd.key_put) begin
            put_en     = idx_ok_reg && !complete_reg;
            put_letter = idx_reg;
        end else if (cmd.fill_step) begin
            put_en = (walk_reg != pfe_pkg::LETTER_J);
        end
    end

    assign do_put = put_en && !used_reg[put_letter] && (fill_reg < pfe_pkg::SQUARE_SIZE);

    // Second letter of the pair: X on end or on a doubled letter
    assign second = (is_end || idx_reg == pend_letter_reg) ? pfe_pkg::LETTER_X : idx_reg;

    assign cells = pfe_pkg::pair_cells(pa_reg, pb_reg);

    // Memory writes and registered reads
    always_ff @(posedge aclk) begin
        if (do_put) begin
            sq_mem[fill_reg]    <= put_letter;
            pos_mem[put_letter] <= fill_reg;
        end
        if (cmd.eval) begin
            pa_reg <= pos_mem[pend_letter_reg];
            pb_reg <= pos_mem[second];
        end
        if (cmd.sq_read) begin
            qa_reg <= sq_mem[cells[9:5]];
            qb_reg <= sq_mem[cells[4:0]];
        end
    end

    // Item capture and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg    <= s_item.action;
            idx_reg    <= in_idx[4:0];
            idx_ok_reg <= in_idx[5];
        end
        if (cmd.eval) begin
            fin_reg <= is_end;
        end
        if (cmd.out_load) begin
            m_item_reg.cipher_first  <= 7'(pfe_pkg::ASCII_A + {3'b000, qa_reg});
            m_item_reg.cipher_second <= 7'(pfe_pkg::ASCII_A + {3'b000, qb_reg});
            m_item_reg.final_pair    <= fin_reg;
        end
    end

    // Control state: square fill, pending letter, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg        <= '0;
            fill_reg        <= '0;
            complete_reg    <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
            walk_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.clear) begin
                used_reg        <= '0;
                fill_reg        <= '0;
                complete_reg    <= 1'b0;
                pend_valid_reg  <= 1'b0;
                pend_letter_reg <= '0;
            end
            if (cmd.load) begin
                walk_reg <= '0;
            end
            if (do_put) begin
                used_reg[put_letter] <= 1'b1;
                fill_reg             <= fill_reg + 5'd1;
            end
            // advance the completion walk over the alphabet
            if (cmd.fill_step) begin
                walk_reg <= walk_reg + 5'd1;
                if (walk_reg == pfe_pkg::LETTER_LAST) begin
                    complete_reg <= 1'b1;
                end
            end
            // update the pending letter
            if (cmd.eval) begin
                if (is_msg && idx_ok_reg) begin
                    if (!pend_valid_reg) begin
                        pend_valid_reg  <= 1'b1;
                        pend_letter_reg <= idx_reg;
                    end else if (idx_reg != pend_letter_reg) begin
                        pend_valid_reg  <= 1'b0;
                        pend_letter_reg <= '0;
                    end
                end else if (is_end) begin
                    pend_valid_reg  <= 1'b0;
                    pend_letter_reg <= '0;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.complete  = complete_reg;
    assign status.walk_last = (walk_reg == pfe_pkg::LETTER_LAST);
    assign status.emit      = pend_valid_reg && ((is_msg && idx_ok_reg) || is_end);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.fill_full = (fill_reg == pfe_pkg::SQUARE_SIZE);

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== rtl/playfair_digraph_encryptor_core.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_item  (action, letter)
// m_        out        m_valid / m_ready  m_item  (cipher_first, cipher_second, final_pair)
//
// States: a clear item is handled in IDLE, a key item passes through KEY, a
// message or end item through EVAL and, with a result, SQ and OUT; the first
// message or end item after reset or a clear also runs the FILL alphabet walk
// that completes the square, one letter a cycle. Memory ports set the pair path:
// the two cell lookups are registered, then the two square reads. Reset is
// synchronous, active low; it clears the flags and counters, the square memories
// are not cleared (entries are always written before use). A result waiting on
// m_ready does not block input; only the next result waits for the output register to free up.
// Top level of the Playfair encryptor; depends on pfe_pkg, pfe_ctrl, pfe_datapath.

module playfair_digraph_encryptor_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pfe_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output pfe_pkg::out_item_t  m_item
);

    pfe_pkg::cmd_t    cmd;
    pfe_pkg::status_t status;

    pfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_item.action),
        .s_ready  (s_ready),
        .cmd      (cmd),
        .status   (status)
    );

    pfe_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

`ifndef NO_ASSERTIONS
    // A new result only enters a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over an unaccepted item");

    // The alphabet walk never runs on a complete square
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_step |-> !status.complete)
        else $error("square walk on a complete square");

    // A complete square holds all 25 letters
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.complete |-> status.fill_full)
        else $error("square complete but not full");

    // Loading a result makes it visible in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");
`endif

endmodule
